>>> hdl/page_table_walk_top_macros.svh
// ---------------------------------------------------------------------------
// Page table walker assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef PAGE_TABLE_WALK_TOP_MACROS_SVH
`define PAGE_TABLE_WALK_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// explicit clock and active-low reset
`define PTW_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// default clock and reset of the block
`define PTW_ASSERT(lbl, prop, msg) \
  `PTW_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define PTW_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define PTW_ASSERT(lbl, prop, msg)
`endif

`endif

>>> hdl/ptw_pkg.sv
// ---------------------------------------------------------------------------
// Page table walker package
// Widths, default parameters, codes and the result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  localparam int unsigned LEVELS     = 4;
  localparam int unsigned INDEX_BITS = 9;
  localparam int unsigned PAGE_BITS  = 12;

  localparam int unsigned VA_W       = 48;
  localparam int unsigned ROOT_W     = 52;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned ENTRY_SHIFT = 3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_RESP  = 1'b1;

  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] read_addr;
    logic [DATA_W-1:0] translated_addr;
    logic              not_mapped;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/page_table_walk_top.sv
// ---------------------------------------------------------------------------
// Page table walker
// Multi-level page table walk through an external table memory port.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries start items (operation 0,
// root_addr and virtual_addr) and table read responses (operation 1,
// read_data). Output channel (out_valid_o / out_stall_i) carries read
// requests (kind 0, read_addr) and walk results (kind 1, translated_addr or
// not_mapped). A start while a walk is open, or a response while idle, is
// taken and dropped without result.
// An item's result is in the output register in the cycle after acceptance,
// and one item can be accepted every cycle while the input does not stall.
// The output register frees in the same cycle it is taken, so the input
// stalls only while a result waits and the receiver stalls.
// kernel_offset is written through cfg_valid_i / cfg_ready_o (always ready);
// the user must write it only while no walk is open; the block does not enforce this.
// Reset makes the walker idle with an empty output register and clears
// kernel_offset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "page_table_walk_top_macros.svh"

module page_table_walk_top #(
  parameter int unsigned LEVELS     = ptw_pkg::LEVELS,
  parameter int unsigned INDEX_BITS = ptw_pkg::INDEX_BITS,
  parameter int unsigned PAGE_BITS  = ptw_pkg::PAGE_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ptw_pkg::DATA_W-1:0]  cfg_wdata_i,
  // input items
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [ptw_pkg::ROOT_W-1:0]  root_addr_i,
  input  wire logic [ptw_pkg::VA_W-1:0]    virtual_addr_i,
  input  wire logic [ptw_pkg::DATA_W-1:0]  read_data_i,
  // result items
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             kind_o,
  output logic [ptw_pkg::DATA_W-1:0]       read_addr_o,
  output logic [ptw_pkg::DATA_W-1:0]       translated_addr_o,
  output logic                             not_mapped_o
);

  localparam int unsigned DW    = ptw_pkg::DATA_W;
  localparam int unsigned VW    = ptw_pkg::VA_W;
  localparam int unsigned LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SH_W  = $clog2(LEVELS * INDEX_BITS + PAGE_BITS + 1);
  localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(LEVELS - 1);

  logic [DW-1:0]     kernel_offset_q;
  logic              busy_q, busy_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic [VW-1:0]     vaddr_q, vaddr_d;
  logic [DW-1:0]     base_q, base_d;
  logic              out_valid_q, out_valid_d;
  ptw_pkg::result_t  res_q, res_d;

  logic              accept;
  logic              start;
  logic              resp;
  logic              entry_zero;
  logic              last_level;
  logic [DW-1:0]     next_base;
  logic [LVL_W-1:0]  ea_level;
  logic [VW-1:0]     ea_vaddr;
  logic [DW-1:0]     ea_base;
  logic [SH_W-1:0]   ea_shift;
  logic [VW-1:0]     ea_vshift;
  logic [DW-1:0]     ea_addr;
  logic [DW-1:0]     final_addr;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign start       = accept & (operation_i == ptw_pkg::OP_START) & ~busy_q;
  assign resp        = accept & (operation_i == ptw_pkg::OP_RESP) & busy_q;

  assign entry_zero  = (read_data_i == '0);
  assign last_level  = (level_q == '0);
  assign next_base   = {read_data_i[DW-1:PAGE_BITS], PAGE_BITS'(0)};

  // shared entry address unit: base + index * 8
  assign ea_level  = start ? TOP_LEVEL : (level_q - LVL_W'(1));
  assign ea_vaddr  = start ? virtual_addr_i : vaddr_q;
  assign ea_base   = start ? DW'(root_addr_i) : next_base;
  assign ea_shift  = SH_W'(ea_level) * SH_W'(INDEX_BITS) + SH_W'(PAGE_BITS);
  assign ea_vshift = ea_vaddr >> ea_shift;
  assign ea_addr   = ea_base + (DW'(ea_vshift[INDEX_BITS-1:0]) << ptw_pkg::ENTRY_SHIFT);

  assign final_addr = (next_base + kernel_offset_q) | DW'(vaddr_q[PAGE_BITS-1:0]);

  always_comb begin
    busy_d      = busy_q;
    level_d     = level_q;
    vaddr_d     = vaddr_q;
    base_d      = base_q;
    out_valid_d = out_valid_q & out_stall_i;
    res_d       = res_q;
    if (start) begin
      busy_d      = 1'b1;
      level_d     = TOP_LEVEL;
      vaddr_d     = virtual_addr_i;
      base_d      = DW'(root_addr_i);
      out_valid_d = 1'b1;
      res_d       = '{kind: ptw_pkg::KIND_REQ, read_addr: ea_addr,
                      translated_addr: '0, not_mapped: 1'b0};
    end else if (resp) begin
      out_valid_d = 1'b1;
      if (entry_zero) begin
        busy_d  = 1'b0;
        level_d = TOP_LEVEL;
        res_d   = '{kind: ptw_pkg::KIND_DONE, read_addr: '0,
                    translated_addr: '0, not_mapped: 1'b1};
      end else if (last_level) begin
        busy_d  = 1'b0;
        level_d = TOP_LEVEL;
        base_d  = next_base;
        res_d   = '{kind: ptw_pkg::KIND_DONE, read_addr: '0,
                    translated_addr: final_addr, not_mapped: 1'b0};
      end else begin
        level_d = level_q - LVL_W'(1);
        base_d  = next_base;
        res_d   = '{kind: ptw_pkg::KIND_REQ, read_addr: ea_addr,
                    translated_addr: '0, not_mapped: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_offset_q <= '0;
      busy_q          <= 1'b0;
      level_q         <= TOP_LEVEL;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        kernel_offset_q <= cfg_wdata_i;
      end
      busy_q      <= busy_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vaddr_q <= vaddr_d;
    base_q  <= base_d;
    res_q   <= res_d;
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = res_q.kind;
  assign read_addr_o       = res_q.read_addr;
  assign translated_addr_o = res_q.translated_addr;
  assign not_mapped_o      = res_q.not_mapped;

  `PTW_ASSERT(a_idle_top_level, !busy_q |-> (level_q == TOP_LEVEL), "idle walker not at top level")
  `PTW_ASSERT(a_stall_needs_result, in_stall_o |-> out_valid_q, "input stalled with empty output")
  `PTW_ASSERT(a_start_requests, start |=> (busy_q && out_valid_q && res_q.kind == ptw_pkg::KIND_REQ), "start gave no read request")
  `PTW_ASSERT(a_end_to_idle, (resp && (entry_zero || last_level)) |=> (!busy_q && out_valid_q && res_q.kind == ptw_pkg::KIND_DONE), "walk end did not return to idle")
  `PTW_ASSERT(a_not_mapped_done, (out_valid_q && res_q.not_mapped) |-> (res_q.kind == ptw_pkg::KIND_DONE && res_q.translated_addr == '0), "not mapped on a non-final item")

endmodule

`default_nettype wire
